[sv/csos_pkg.sv]
// package: shared constants and types for the subarray or search block
`timescale 1ns / 1ps
package csos_pkg;
  localparam int MAX_ITEMS = 1024;
  localparam int VALUE_BITS = 30;
  localparam int POS_BITS = $clog2(MAX_ITEMS);
  localparam int NODE_BITS = POS_BITS + 1;
  localparam int CNT_BITS = POS_BITS + 1;
  localparam int TREE_SIZE = 2 * MAX_ITEMS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR_STEP,
    CMD_WRITE_LEAF,
    CMD_WRITE_UP,
    CMD_QUERY_START,
    CMD_QUERY_STEP,
    CMD_SEARCH_INIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic search_two;
  } dp_cmd_t;

  typedef struct packed {
    logic at_root;
    logic query_done;
    logic search_done;
    logic clear_done;
    logic full;
  } dp_status_t;
endpackage

[sv/csos_if.sv]
// interfaces: input word, result word and configuration write channels
`timescale 1ns / 1ps
interface csos_in_if;
  import csos_pkg::*;
  logic valid;
  logic ready;
  logic [29:0] element;
  logic restart;
  modport source (output valid, element, restart, input ready);
  modport sink (input valid, element, restart, output ready);
endinterface

interface csos_out_if;
  logic valid;
  logic ready;
  logic [29:0] best_difference;
  logic overflow;
  modport source (output valid, best_difference, overflow, input ready);
  modport sink (input valid, best_difference, overflow, output ready);
endinterface

interface csos_cfg_if;
  logic valid;
  logic ready;
  logic [29:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/closest_subarray_or_search.sv]
// top level: streaming closest subarray or search over an or segment tree
//
// in: one word per array element (element, restart); restart starts a new
// array, clears the tree, the count and the best difference.
// out: one word per input word with the best |or - target| so far and an
// overflow flag when the array already holds 1024 elements.
// cfg: writes the 30-bit target; write only while idle.
// steps: the clear state waits for any clearing pass, the leaf is written,
// then each parent up to the root is read and written, then two binary
// searches of up to 11 probes each run; a probe is a range or walk over the
// tree, with each node read registered before it is or-ed in. an overflow
// result goes from the clear state straight to the result word. one word is
// in flight at a time; the next word can be taken the cycle after the result
// leaves. after reset and after each restart a clearing pass sweeps all 2048
// tree memory entries before the element is written.
// a stalled result holds the block; the next word waits until it is taken.
`timescale 1ns / 1ps
module closest_subarray_or_search (
  input logic clk,
  input logic rst,
  csos_in_if.sink in,
  csos_out_if.source out,
  csos_cfg_if.sink cfg
);
  import csos_pkg::*;

  dp_cmd_t cmd;
  dp_status_t status;
  logic take;
  value_t target;
  value_t best;
  logic ovf;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) target <= '0;
    else if (cfg.valid) target <= cfg.data;
  end

  csos_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid),
    .in_ready(in.ready), .out_valid(out.valid), .out_ready(out.ready),
    .out_overflow(ovf), .cmd(cmd), .take(take), .status(status)
  );

  csos_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .take(take), .restart(in.restart),
    .element(in.element), .target(target), .status(status), .best(best)
  );

  assign out.best_difference = best;
  assign out.overflow = ovf;
endmodule

[sv/csos_datapath.sv]
// datapath: or tree memory, range query walker and binary search registers
`timescale 1ns / 1ps
module csos_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  csos_pkg::dp_cmd_t     cmd,
  input  logic                  take,
  input  logic                  restart,
  input  csos_pkg::value_t      element,
  input  csos_pkg::value_t      target,
  output csos_pkg::dp_status_t  status,
  output csos_pkg::value_t      best
);
  import csos_pkg::*;

  value_t mem [TREE_SIZE];
  value_t rd_data;
  value_t sib_data;
  node_t  wr_node;
  node_t  rd_addr;
  value_t leaf_val;
  node_t  clr_idx;
  logic   clr_busy;
  cnt_t   count;
  pos_t   cur;
  // query walker
  logic [NODE_BITS:0] qa;
  logic [NODE_BITS:0] qb;
  logic [NODE_BITS:0] qb_dec;
  value_t acc;
  logic   q_done;
  logic   rd_pend;
  // binary search
  logic signed [CNT_BITS:0] lo;
  logic signed [CNT_BITS:0] hi;
  logic signed [CNT_BITS:0] mid;
  logic   s_done;
  logic   have;
  value_t found;
  value_t bestr;
  value_t diff;

  assign mid = (lo + hi) >> 1;
  assign qb_dec = qb - (NODE_BITS+1)'(1);
  assign status.full = (count == cnt_t'(MAX_ITEMS));
  assign status.clear_done = !clr_busy;
  assign status.query_done = q_done;
  assign status.search_done = s_done;
  assign status.at_root = ((wr_node >> 1) == node_t'(1));
  assign best = bestr;
  assign diff = (found >= target) ? found - target : target - found;

  // tree write port / read port
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_idx] <= '0;
    end else if (cmd.op == CMD_WRITE_LEAF) begin
      mem[{1'b1, count[POS_BITS-1:0]}] <= leaf_val;
    end else if (cmd.op == CMD_WRITE_UP) begin
      mem[wr_node >> 1] <= rd_data | sib_data;
    end
    rd_data <= mem[rd_addr];
    sib_data <= mem[rd_addr ^ node_t'(1)];
  end

  always_comb begin
    rd_addr = wr_node;
    if (cmd.op == CMD_QUERY_STEP) begin
      rd_addr = qa[0] ? qa[NODE_BITS-1:0] : qb_dec[NODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx <= '0;
      count <= '0;
      bestr <= '1;
      q_done <= 1'b0;
      s_done <= 1'b0;
      rd_pend <= 1'b0;
      have <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + node_t'(1);
        if (clr_idx == node_t'(TREE_SIZE - 1)) clr_busy <= 1'b0;
      end
      if (take) begin
        leaf_val <= element;
        if (restart) begin
          count <= '0;
          bestr <= '1;
          clr_busy <= 1'b1;
          clr_idx <= '0;
        end
      end
      case (cmd.op)
        CMD_WRITE_LEAF: begin
          cur <= count[POS_BITS-1:0];
          wr_node <= {1'b1, count[POS_BITS-1:0]};
          count <= count + cnt_t'(1);
        end
        CMD_WRITE_UP: begin
          wr_node <= wr_node >> 1;
        end
        CMD_SEARCH_INIT: begin
          if (have) begin
            if (diff < bestr) bestr <= diff;
          end
          lo <= '0;
          hi <= {2'b0, cur};
          have <= 1'b0;
          s_done <= 1'b0;
          found <= '0;
        end
        CMD_QUERY_START: begin
          if (lo > hi) begin
            s_done <= 1'b1;
          end else begin
            qa <= {2'b01, mid[POS_BITS-1:0]};
            qb <= {2'b01, cur} + (NODE_BITS+1)'(1);
            acc <= '0;
            q_done <= 1'b0;
            rd_pend <= 1'b0;
          end
        end
        CMD_QUERY_STEP: begin
          if (q_done) begin
            q_done <= 1'b0;
            if (!cmd.search_two) begin
              if (acc <= target) begin
                have <= 1'b1;
                found <= acc;
                if (acc == target) s_done <= 1'b1;
                hi <= mid - (CNT_BITS+1)'(1);
              end else begin
                lo <= mid + (CNT_BITS+1)'(1);
              end
            end else begin
              if (acc > target) begin
                have <= 1'b1;
                found <= acc;
                lo <= mid + (CNT_BITS+1)'(1);
              end else begin
                hi <= mid - (CNT_BITS+1)'(1);
              end
            end
          end else if (rd_pend) begin
            acc <= acc | rd_data;
            rd_pend <= 1'b0;
          end else if (qa >= qb) begin
            q_done <= 1'b1;
          end else if (qa[0]) begin
            rd_pend <= 1'b1;
            qa <= qa + (NODE_BITS+1)'(1);
          end else if (qb[0]) begin
            rd_pend <= 1'b1;
            qb <= qb_dec;
          end else begin
            qa <= qa >> 1;
            qb <= qb >> 1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && cmd.op == CMD_QUERY_STEP && !rd_pend && qb < qa) begin
      $error("query window inverted");
    end
  end

  property p_lo_bound;
    @(posedge clk) disable iff (rst) (cmd.op == CMD_QUERY_START && !(lo > hi))
      |=> (qa <= qb);
  endproperty
  a_lo_bound: assert property (p_lo_bound) else $error("query bounds wrong");

  property p_count;
    @(posedge clk) disable iff (rst) (count <= cnt_t'(MAX_ITEMS));
  endproperty
  a_count: assert property (p_count) else $error("count beyond capacity");

  property p_best_restart;
    @(posedge clk) disable iff (rst) (take && restart) |=> (bestr == '1);
  endproperty
  a_best_restart: assert property (p_best_restart) else $error("best not reset");
endmodule

[sv/csos_ctrl.sv]
// controller: sequences clearing, tree update, two searches and the result word
`timescale 1ns / 1ps
module csos_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_overflow,
  output csos_pkg::dp_cmd_t     cmd,
  output logic                  take,
  input  csos_pkg::dp_status_t  status
);
  import csos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LEAF, S_UP_RD, S_UP_WR, S_INIT1, S_QSTART, S_QSTEP,
    S_INIT2, S_FINAL, S_OUT
  } state_t;

  state_t state;
  logic two;

  assign in_ready = (state == S_IDLE) && status.clear_done;
  assign take = in_valid && in_ready;
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.search_two = two;
    case (state)
      S_LEAF: cmd.op = CMD_WRITE_LEAF;
      S_UP_WR: cmd.op = CMD_WRITE_UP;
      S_INIT1, S_INIT2, S_FINAL: cmd.op = CMD_SEARCH_INIT;
      S_QSTART: cmd.op = CMD_QUERY_START;
      S_QSTEP: cmd.op = CMD_QUERY_STEP;
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      two <= 1'b0;
      out_overflow <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (status.clear_done) begin
            if (status.full) begin
              out_overflow <= 1'b1;
              state <= S_OUT;
            end else begin
              out_overflow <= 1'b0;
              state <= S_LEAF;
            end
          end
        end
        S_LEAF: state <= S_UP_RD;
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: state <= status.at_root ? S_INIT1 : S_UP_RD;
        S_INIT1: begin
          two <= 1'b0;
          state <= S_QSTART;
        end
        S_QSTART: state <= S_QSTEP;
        S_QSTEP: begin
          if (status.search_done) begin
            state <= two ? S_FINAL : S_INIT2;
          end else if (status.query_done) begin
            state <= S_QSTART;
          end
        end
        S_INIT2: begin
          two <= 1'b1;
          state <= S_QSTART;
        end
        S_FINAL: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_one_side;
    @(posedge clk) disable iff (rst) !(in_ready && out_valid);
  endproperty
  a_one_side: assert property (p_one_side) else $error("accept while result pending");

  property p_out_hold;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_take_clear;
    @(posedge clk) disable iff (rst) take |=> (state == S_CLEAR);
  endproperty
  a_take_clear: assert property (p_take_clear) else $error("bad start");
endmodule
